// ----- rtl/wgm_pkg.sv -----
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 6;
   localparam int INDEX_W     = 5;

   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_BEGIN = 2'd1,
      REQ_TEXT  = 2'd2
   } wgm_req_type;

   // Signals that every cell sees in the same cycle.
   typedef struct packed {
      logic              begin_step;
      logic              text_step;
      logic [CHAR_W-1:0] text_char;
   } wgm_bcast_type;

   // Prefix bits handed from one cell to the next.
   typedef struct packed {
      logic cur;
      logic nxt;
   } wgm_link_type;

endpackage

// ----- rtl/wgm_cell.sv -----
// One pattern position: its byte and the match bit for the prefix that ends there.
module wgm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  wgm_pkg::wgm_bcast_type     bcast,
   input  logic                       load_en,
   input  logic [wgm_pkg::CHAR_W-1:0] load_char,
   input  logic                       active,
   input  wgm_pkg::wgm_link_type      link_in,
   output wgm_pkg::wgm_link_type      link_out
);

   logic [wgm_pkg::CHAR_W-1:0] pat_ff;
   logic                       bit_ff;
   logic                       bit_in;
   logic                       is_star;
   logic                       hit;
   logic                       stored;
   logic                       nxt_raw;

   always_ff @(posedge clock) begin
      if (load_en) begin
         pat_ff <= load_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   always_comb begin
      is_star = (pat_ff == wgm_pkg::STAR_CHAR);
      hit     = (pat_ff == wgm_pkg::ANY_CHAR) || (pat_ff == bcast.text_char);
      // A begin item starts from the empty text, so every stored bit above zero is cleared.
      stored  = bit_ff & ~bcast.begin_step;
      // A star matches the empty run, so the bit to the left carries through it.
      link_out.cur = stored | (active & is_star & link_in.cur);
      nxt_raw = active & (is_star ? link_out.cur : (link_in.cur & hit));
      link_out.nxt = nxt_raw | (active & is_star & link_in.nxt);
      bit_in = bit_ff;
      if (bcast.begin_step) begin
         bit_in = 1'b0;
      end else if (bcast.text_step) begin
         bit_in = link_out.nxt;
      end
   end

endmodule

// ----- rtl/wgm_rsp_buf.sv -----
// Two-entry result buffer that lets a new request in while a result is waiting.
module wgm_rsp_buf (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_matched,
   output logic space,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_matched
);

   logic main_valid_ff, main_valid_in;
   logic main_matched_ff, main_matched_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_matched_ff, skid_matched_in;
   logic pop;

   always_comb begin
      pop             = main_valid_ff & rsp_ready;
      main_valid_in   = main_valid_ff;
      main_matched_in = main_matched_ff;
      skid_valid_in   = skid_valid_ff;
      skid_matched_in = skid_matched_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_matched_in = skid_matched_ff;
            skid_valid_in   = 1'b0;
         end else begin
            main_valid_in   = push;
            main_matched_in = push_matched;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in   = 1'b1;
            skid_matched_in = push_matched;
         end else begin
            main_valid_in   = 1'b1;
            main_matched_in = push_matched;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_matched_ff <= main_matched_in;
      skid_matched_ff <= skid_matched_in;
   end

   assign space       = ~skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_matched = main_matched_ff;

endmodule

// ----- rtl/wildcard_glob_matcher.sv -----
// Wildcard glob matcher top level: a row of pattern cells and the result buffer.
// Each result is registered in the result buffer at its request transfer.
// One request per cycle while req_ready is high; the star carry ripples through the cell row.
// A result held back by the consumer still leaves room for one more request.
// Reset clears the pattern length to zero and the prefix bits to the empty text.
// Pattern bytes are not reset and must be loaded before use.
module wildcard_glob_matcher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [wgm_pkg::INDEX_W-1:0] req_pattern_index,
   input  logic [wgm_pkg::CHAR_W-1:0]  req_char_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_matched,
   input  logic                        csr_wr_en,
   input  logic [wgm_pkg::LEN_W-1:0]   csr_wr_data
);

   logic [wgm_pkg::LEN_W-1:0]      len_ff, len_in;
   logic                           bit0_ff, bit0_in;
   logic                           accept;
   wgm_pkg::wgm_req_type           kind;
   wgm_pkg::wgm_bcast_type         bcast;
   logic                           load_step;
   wgm_pkg::wgm_link_type          links [wgm_pkg::MAX_PATTERN+1];
   logic [wgm_pkg::MAX_PATTERN:0]  cur_vec;
   logic [wgm_pkg::MAX_PATTERN:0]  nxt_vec;
   logic                           result;

   assign accept = req_valid & req_ready;
   assign kind   = wgm_pkg::wgm_req_type'(req_type);

   always_comb begin
      bcast.begin_step = 1'b0;
      bcast.text_step  = 1'b0;
      bcast.text_char  = req_char_value;
      load_step        = 1'b0;
      case (kind)
         wgm_pkg::REQ_LOAD:  load_step        = accept;
         wgm_pkg::REQ_BEGIN: bcast.begin_step = accept;
         wgm_pkg::REQ_TEXT:  bcast.text_step  = accept;
         default: begin
            load_step = 1'b0;
         end
      endcase
   end

   // Lengths beyond the cell count saturate.
   always_comb begin
      len_in = len_ff;
      if (csr_wr_en) begin
         if (csr_wr_data > wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN)) begin
            len_in = wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN);
         end else begin
            len_in = csr_wr_data;
         end
      end
   end

   // Bit zero is the empty prefix; any text byte clears it.
   always_comb begin
      bit0_in = bit0_ff;
      if (bcast.begin_step) begin
         bit0_in = 1'b1;
      end else if (bcast.text_step) begin
         bit0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         bit0_ff <= 1'b1;
      end else begin
         len_ff  <= len_in;
         bit0_ff <= bit0_in;
      end
   end

   assign links[0].cur = bit0_ff | bcast.begin_step;
   assign links[0].nxt = 1'b0;
   assign cur_vec[0]   = links[0].cur;
   assign nxt_vec[0]   = links[0].nxt;

   for (genvar j = 1; j <= wgm_pkg::MAX_PATTERN; j++) begin : g_cell
      wgm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .load_en   (load_step &&
                     (req_pattern_index == wgm_pkg::INDEX_W'(j - 1))),
         .load_char (req_char_value),
         .active    (len_ff >= wgm_pkg::LEN_W'(j)),
         .link_in   (links[j-1]),
         .link_out  (links[j])
      );
      assign cur_vec[j] = links[j].cur;
      assign nxt_vec[j] = links[j].nxt;
   end

   always_comb begin
      result = 1'b0;
      case (kind)
         wgm_pkg::REQ_BEGIN: result = cur_vec[len_ff];
         wgm_pkg::REQ_TEXT:  result = nxt_vec[len_ff];
         default: begin
            result = 1'b0;
         end
      endcase
   end

   wgm_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .push         (accept),
      .push_matched (result),
      .space        (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_matched  (rsp_matched)
   );

`ifndef SYNTHESIS
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN))
      else $error("pattern length above cell count");

   a_begin_sets_bit0: assert property (@(posedge clock) disable iff (reset)
      bcast.begin_step |=> bit0_ff)
      else $error("begin transfer did not restore the empty prefix");

   a_text_clears_bit0: assert property (@(posedge clock) disable iff (reset)
      bcast.text_step |=> !bit0_ff)
      else $error("text transfer left the empty prefix set");

   a_load_no_result_match: assert property (@(posedge clock) disable iff (reset)
      (load_step && !rsp_valid) |=> (rsp_valid && !rsp_matched))
      else $error("load transfer produced a matching result");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the wildcard glob matcher.
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] REQ_RESERVED = 2'd3;
   localparam logic [7:0] LETTER_A     = 8'h61;
   localparam logic [7:0] LETTER_B     = 8'h62;
   localparam logic [7:0] LETTER_X     = 8'h78;
   localparam int         ITEM_TARGET  = 800;

   // Predicts the matched flag from its own copy of the pattern and prefix bits.
   class match_scoreboard;
      logic [wgm_pkg::CHAR_W-1:0]    pattern [wgm_pkg::MAX_PATTERN];
      logic [wgm_pkg::MAX_PATTERN:0] prefix_bits;
      int unsigned                   span;
      bit                            expected_q[$];

      function new();
         prefix_bits = 1;
         span = 0;
         foreach (pattern[j]) pattern[j] = '0;
      endfunction

      function void set_length(logic [wgm_pkg::LEN_W-1:0] value);
         span = (value > wgm_pkg::MAX_PATTERN) ? wgm_pkg::MAX_PATTERN : value;
      endfunction

      // A star lets the prefix before it count as matched after it as well.
      function logic [wgm_pkg::MAX_PATTERN:0] star_carry(logic [wgm_pkg::MAX_PATTERN:0] bits);
         for (int j = 1; j <= span; j++) begin
            if (pattern[j-1] == wgm_pkg::STAR_CHAR && bits[j-1]) bits[j] = 1'b1;
         end
         return bits;
      endfunction

      function void note_request(logic [1:0] kind, logic [wgm_pkg::INDEX_W-1:0] idx,
                                 logic [wgm_pkg::CHAR_W-1:0] ch);
         logic [wgm_pkg::MAX_PATTERN:0] cur;
         logic [wgm_pkg::MAX_PATTERN:0] nxt;
         bit hit;
         hit = 1'b0;
         case (kind)
            wgm_pkg::REQ_LOAD: begin
               pattern[idx] = ch;
            end
            wgm_pkg::REQ_BEGIN: begin
               prefix_bits = 1;
               cur = star_carry(prefix_bits);
               hit = cur[span];
            end
            wgm_pkg::REQ_TEXT: begin
               cur = star_carry(prefix_bits);
               nxt = '0;
               for (int j = 1; j <= span; j++) begin
                  if (pattern[j-1] == wgm_pkg::STAR_CHAR) begin
                     nxt[j] = cur[j];
                  end else begin
                     nxt[j] = cur[j-1] && (pattern[j-1] == ch ||
                                           pattern[j-1] == wgm_pkg::ANY_CHAR);
                  end
               end
               nxt = star_carry(nxt);
               prefix_bits = nxt;
               hit = nxt[span];
            end
            default: ;
         endcase
         expected_q = {expected_q, hit};
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit check_result(logic got, output bit want);
         want = expected_q.pop_front();
         return got === want;
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [1:0]                    req_type;
   logic [wgm_pkg::INDEX_W-1:0]   req_pattern_index;
   logic [wgm_pkg::CHAR_W-1:0]    req_char_value;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_matched;
   logic                          csr_wr_en;
   logic [wgm_pkg::LEN_W-1:0]     csr_wr_data;

   match_scoreboard               sb = new();
   int                            failures = 0;
   int                            items_sent = 0;
   int                            send_idle_pct = 0;
   int                            recv_stall_pct = 0;
   logic [wgm_pkg::CHAR_W-1:0]    pattern_shadow [wgm_pkg::MAX_PATTERN];
   int                            length_shadow = 0;

   wildcard_glob_matcher uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_pattern_index (req_pattern_index),
      .req_char_value    (req_char_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      failures++;
   endtask

   // Input transfers feed the predictor; result transfers are checked in order.
   always @(posedge clock) begin : watch
      bit want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_type, req_pattern_index, req_char_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (sb.pending() == 0) begin
               report_mismatch("result transfer with no expectation waiting");
            end else if (!sb.check_result(rsp_matched, want)) begin
               report_mismatch($sformatf("matched is %b, expected %b", rsp_matched, want));
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic send_request(input logic [1:0] kind,
                               input logic [wgm_pkg::INDEX_W-1:0] idx,
                               input logic [wgm_pkg::CHAR_W-1:0] ch);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_pattern_index <= idx;
      req_char_value    <= ch;
      if (kind == wgm_pkg::REQ_LOAD) pattern_shadow[idx] = ch;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Returns at a clock edge once every outstanding result has been transferred.
   // The first edge lets the watcher note the last input transfer.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_length(input logic [wgm_pkg::LEN_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_length(value);
      length_shadow = (value > wgm_pkg::MAX_PATTERN) ? wgm_pkg::MAX_PATTERN : value;
   endtask

   function automatic logic [wgm_pkg::CHAR_W-1:0] pick_glob_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return wgm_pkg::STAR_CHAR;
      if (roll < 45) return wgm_pkg::ANY_CHAR;
      if (roll < 70) return LETTER_A;
      if (roll < 95) return LETTER_B;
      return wgm_pkg::CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [wgm_pkg::CHAR_W-1:0] pick_text_char();
      if ($urandom_range(0, 99) < 5) return wgm_pkg::CHAR_W'($urandom_range(0, 255));
      return $urandom_range(0, 1) ? LETTER_A : LETTER_B;
   endfunction

   // Up to two pattern loads, a begin, then a text built to fit the pattern, with a few errors mixed in.
   task automatic glob_sequence();
      logic [wgm_pkg::CHAR_W-1:0] text_q[$];
      logic [wgm_pkg::CHAR_W-1:0] p;
      int j;
      repeat ($urandom_range(0, 2)) begin
         send_request(wgm_pkg::REQ_LOAD,
                      wgm_pkg::INDEX_W'($urandom_range(0, wgm_pkg::MAX_PATTERN - 1)),
                      pick_glob_char());
      end
      send_request(wgm_pkg::REQ_BEGIN,
                   wgm_pkg::INDEX_W'($urandom_range(0, wgm_pkg::MAX_PATTERN - 1)),
                   wgm_pkg::CHAR_W'($urandom_range(0, 255)));
      for (j = 0; j < length_shadow; j++) begin
         p = pattern_shadow[j];
         if (p == wgm_pkg::STAR_CHAR) begin
            repeat ($urandom_range(0, 3)) text_q = {text_q, pick_text_char()};
         end else if (p == wgm_pkg::ANY_CHAR) begin
            text_q = {text_q, pick_text_char()};
         end else if ($urandom_range(0, 99) < 6) begin
            text_q = {text_q, pick_text_char()};
         end else begin
            text_q = {text_q, p};
         end
      end
      if ($urandom_range(0, 99) < 10) text_q = {text_q, pick_text_char()};
      foreach (text_q[k]) begin
         send_request(wgm_pkg::REQ_TEXT,
                      wgm_pkg::INDEX_W'($urandom_range(0, wgm_pkg::MAX_PATTERN - 1)),
                      text_q[k]);
      end
   endtask

   task automatic noise_item();
      send_request(2'($urandom_range(0, 3)),
                   wgm_pkg::INDEX_W'($urandom_range(0, wgm_pkg::MAX_PATTERN - 1)),
                   wgm_pkg::CHAR_W'($urandom_range(0, 255)));
   endtask

   initial begin : limit
      #5_000_000;
      $display("Timeout: results still outstanding");
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int phase_end;
      logic [wgm_pkg::LEN_W-1:0] phase_length [6];
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = wgm_pkg::REQ_LOAD;
      req_pattern_index = '0;
      req_char_value    = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      foreach (pattern_shadow[j]) pattern_shadow[j] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern: text before any begin, a reserved request, the empty text and one byte, then pattern loads.
      send_request(wgm_pkg::REQ_TEXT, 5'd31, 8'hFF);
      send_request(REQ_RESERVED, 5'd31, 8'hFF);
      send_request(wgm_pkg::REQ_BEGIN, 5'd0, 8'h00);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, 8'h00);
      send_request(wgm_pkg::REQ_LOAD, 5'd0, wgm_pkg::STAR_CHAR);
      send_request(wgm_pkg::REQ_LOAD, 5'd1, wgm_pkg::ANY_CHAR);
      send_request(wgm_pkg::REQ_LOAD, 5'd2, LETTER_A);
      send_request(wgm_pkg::REQ_LOAD, 5'd31, 8'hFF);
      send_request(wgm_pkg::REQ_LOAD, 5'd30, 8'h00);
      write_length(6'd3);
      send_request(wgm_pkg::REQ_BEGIN, 5'd0, 8'h00);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, LETTER_X);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, LETTER_A);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, LETTER_A);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, 8'h00);
      // The last pattern byte changes while a text is in progress.
      send_request(wgm_pkg::REQ_LOAD, 5'd2, 8'h00);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, 8'h00);
      send_request(REQ_RESERVED, 5'd0, 8'h00);
      send_request(wgm_pkg::REQ_BEGIN, 5'd0, 8'h00);
      // An all-star pattern matches the empty text and everything after it.
      send_request(wgm_pkg::REQ_LOAD, 5'd1, wgm_pkg::STAR_CHAR);
      send_request(wgm_pkg::REQ_LOAD, 5'd2, wgm_pkg::STAR_CHAR);
      send_request(wgm_pkg::REQ_BEGIN, 5'd0, 8'h00);
      send_request(wgm_pkg::REQ_TEXT, 5'd0, 8'hFF);
      drain();

      // Fill the whole store so that any length reads only loaded entries.
      for (int j = 0; j < wgm_pkg::MAX_PATTERN; j++) begin
         send_request(wgm_pkg::REQ_LOAD, wgm_pkg::INDEX_W'(j), pick_glob_char());
      end

      phase_length[0] = 6'd32;
      phase_length[1] = 6'd63;
      phase_length[2] = 6'd0;
      phase_length[3] = 6'd1;
      phase_length[4] = 6'd33;
      phase_length[5] = wgm_pkg::LEN_W'($urandom_range(2, 63));
      for (int p = 0; p < 6; p++) begin
         write_length(phase_length[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         phase_end = items_sent + (ITEM_TARGET - items_sent) / (6 - p);
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 70) begin
               glob_sequence();
            end else begin
               repeat ($urandom_range(1, 4)) noise_item();
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
